// ===== src/tcw_pkg.sv =====
// Shared types and constants of the text console writer.
// Used by tcw_cell_ram, text_console_writer_top and tcw_checker; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package tcw_pkg;

  // Screen geometry and cell memory size
  localparam int COLUMNS      = 80;
  localparam int ROWS         = 25;
  localparam int MEMORY_CELLS = 8192;
  localparam int SCREEN_CELLS = COLUMNS * ROWS;

  localparam int ADDR_W = 13;
  localparam int COL_W  = 7;
  localparam int ROW_W  = 5;
  localparam int CNT_W  = $clog2(MEMORY_CELLS + 1);
  localparam int CELL_W = 16;

  // A scroll that keeps start below this bound still fits one blank row below the screen
  localparam int SCROLL_LIMIT = MEMORY_CELLS - SCREEN_CELLS - COLUMNS;

  localparam logic [CELL_W-1:0] BLANK_CELL   = 16'h0720;
  localparam logic [7:0]        ATTR_DEFAULT = 8'h07;

  // Item modes
  localparam logic [1:0] MODE_WRITE = 2'd0;
  localparam logic [1:0] MODE_READ  = 2'd1;
  localparam logic [1:0] MODE_CLEAR = 2'd2;

  // Control codes
  localparam logic [7:0] CH_NUL = 8'h00;
  localparam logic [7:0] CH_BEL = 8'h07;
  localparam logic [7:0] CH_BS  = 8'h08;
  localparam logic [7:0] CH_HT  = 8'h09;
  localparam logic [7:0] CH_LF  = 8'h0A;
  localparam logic [7:0] CH_VT  = 8'h0B;
  localparam logic [7:0] CH_FF  = 8'h0C;
  localparam logic [7:0] CH_CR  = 8'h0D;
  localparam logic [7:0] CH_DEL = 8'h7F;

  // Register map: index taken from paddr[2]
  localparam logic REG_TEXT_ATTRIBUTE = 1'b0;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_BLANK,
    ST_COPY,
    ST_TAIL,
    ST_DONE
  } state_t;

  // Work left after a line feed
  typedef enum logic [1:0] {
    TAIL_NONE,
    TAIL_CR,
    TAIL_PUT
  } tail_t;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [CELL_W-1:0] wdata;
    logic [ADDR_W-1:0] raddr;
  } ram_req_t;

endpackage

`default_nettype wire

// ===== src/tcw_cell_ram.sv =====
// Text cell memory: one write port, one read port with registered data.
// Depends on tcw_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tcw_cell_ram (
  input  wire logic                      clk,
  input  wire tcw_pkg::ram_req_t         req,
  output logic [tcw_pkg::CELL_W-1:0]     rdata
);

  logic [tcw_pkg::CELL_W-1:0] mem [tcw_pkg::MEMORY_CELLS];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[req.raddr];
  end

endmodule

`default_nettype wire

// ===== src/text_console_writer_top.sv =====
// Text console writer top level: sequencer, cursor state and APB register.
// Depends on tcw_pkg and tcw_cell_ram.
`timescale 1ns / 1ps
`default_nettype none

// An 80x25 text console over an 8192-cell memory (attribute high byte,
// character low byte). An item is taken when start is high and busy is low;
// its result appears for one cycle with done high, and the receiver cannot
// hold it off. Every result carries the cursor, start and shown cursor as
// they stand after the item; read_cell is the cell read in read mode and 0
// otherwise. Plain characters, BS, DEL, CR, ignored codes and unused mode
// finish in the accept step and go straight to ST_DONE; reads pass through
// ST_READ, and line feeds and a character that takes a pending wrap through
// ST_TAIL. A line feed on the last row first blanks the row below the screen
// in ST_BLANK or, once start reaches SCROLL_LIMIT, copies the screen back to
// cell 0 in ST_COPY; clear sweeps every cell in ST_CLEAR. These long steps
// are set by the single write port of the cell memory, which moves one cell
// per cycle. After reset the block runs a clearing pass over every cell with
// busy high; register writes are taken during it.
module text_console_writer_top (
  input  wire logic                        clk,
  input  wire logic                        rst,
  // item channel
  input  wire logic                        start,
  output logic                             busy,
  input  wire logic [1:0]                  mode,
  input  wire logic [7:0]                  char_code,
  input  wire logic                        last_in_write,
  input  wire logic [tcw_pkg::ADDR_W-1:0]  cell_index,
  // result channel
  output logic                             done,
  output logic [tcw_pkg::CELL_W-1:0]       read_cell,
  output logic [tcw_pkg::ADDR_W-1:0]       display_start,
  output logic [tcw_pkg::ADDR_W-1:0]       hw_cursor,
  output logic [tcw_pkg::COL_W-1:0]        cursor_column,
  output logic [tcw_pkg::ROW_W-1:0]        cursor_row,
  // configuration port
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [2:0]                  paddr,
  input  wire logic [31:0]                 pwdata,
  output logic [31:0]                      prdata,
  output logic                             pready
);

  localparam int AW = tcw_pkg::ADDR_W;
  localparam int CW = tcw_pkg::COL_W;
  localparam int RW = tcw_pkg::ROW_W;
  localparam int NW = tcw_pkg::CNT_W;

  // Control state
  tcw_pkg::state_t state, state_next;
  logic [NW-1:0]   cnt, cnt_next;
  logic            clear_item, clear_item_next;
  logic [AW-1:0]   start_cell, start_cell_next;
  logic [AW-1:0]   cursor_cell, cursor_cell_next;
  logic [CW-1:0]   column, column_next;
  logic [RW-1:0]   row, row_next;
  logic [AW-1:0]   shown_cursor, shown_cursor_next;
  logic [7:0]      text_attribute;

  // Item payload held across the multi-cycle steps
  logic [7:0]                  char_q, char_q_next;
  logic                        last_q, last_q_next;
  logic                        write_q, write_q_next;
  tcw_pkg::tail_t              tail_q, tail_q_next;
  logic [tcw_pkg::CELL_W-1:0]  read_q, read_q_next;

  tcw_pkg::ram_req_t           ram_req;
  logic [tcw_pkg::CELL_W-1:0]  ram_rdata;

  // Character decode straight from the ports, used in the accept cycle
  logic is_ign, is_bs, is_del, is_lf, is_ff, is_cr, is_put;
  logic wrap_pending, need_lf, at_last_row, scroll_fits;
  logic clear_end, blank_end, copy_end;
  logic cur_write, cur_last;
  logic cfg_write;

  assign is_ign = char_code inside {tcw_pkg::CH_NUL, tcw_pkg::CH_BEL,
                                    tcw_pkg::CH_HT, tcw_pkg::CH_VT};
  assign is_bs  = (char_code == tcw_pkg::CH_BS);
  assign is_del = (char_code == tcw_pkg::CH_DEL);
  assign is_lf  = (char_code == tcw_pkg::CH_LF);
  assign is_ff  = (char_code == tcw_pkg::CH_FF);
  assign is_cr  = (char_code == tcw_pkg::CH_CR);
  assign is_put = !(is_ign || is_bs || is_del || is_lf || is_ff || is_cr);

  assign wrap_pending = (column >= CW'(tcw_pkg::COLUMNS));
  assign need_lf      = is_lf || is_ff || (is_put && wrap_pending);
  assign at_last_row  = (row == RW'(tcw_pkg::ROWS - 1));
  assign scroll_fits  = (start_cell < AW'(tcw_pkg::SCROLL_LIMIT));

  assign clear_end = (cnt == NW'(tcw_pkg::MEMORY_CELLS - 1));
  assign blank_end = (cnt == NW'(tcw_pkg::COLUMNS - 1));
  assign copy_end  = (cnt == NW'(tcw_pkg::SCREEN_CELLS));

  // Item flags: from the ports while accepting, from the held copy later
  assign cur_write = (state == tcw_pkg::ST_IDLE) ? (mode == tcw_pkg::MODE_WRITE) : write_q;
  assign cur_last  = (state == tcw_pkg::ST_IDLE) ? last_in_write : last_q;

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      tcw_pkg::ST_CLEAR: begin
        if (clear_end) begin
          state_next = clear_item ? tcw_pkg::ST_DONE : tcw_pkg::ST_IDLE;
        end
      end
      tcw_pkg::ST_IDLE: begin
        if (start) begin
          case (mode)
            tcw_pkg::MODE_WRITE: begin
              if (!need_lf) begin
                state_next = tcw_pkg::ST_DONE;
              end else if (!at_last_row) begin
                state_next = tcw_pkg::ST_TAIL;
              end else if (scroll_fits) begin
                state_next = tcw_pkg::ST_BLANK;
              end else begin
                state_next = tcw_pkg::ST_COPY;
              end
            end
            tcw_pkg::MODE_READ:  state_next = tcw_pkg::ST_READ;
            tcw_pkg::MODE_CLEAR: state_next = tcw_pkg::ST_CLEAR;
            default:             state_next = tcw_pkg::ST_DONE;
          endcase
        end
      end
      tcw_pkg::ST_READ:  state_next = tcw_pkg::ST_DONE;
      tcw_pkg::ST_BLANK: if (blank_end) state_next = tcw_pkg::ST_TAIL;
      tcw_pkg::ST_COPY:  if (copy_end) state_next = tcw_pkg::ST_TAIL;
      tcw_pkg::ST_TAIL:  state_next = tcw_pkg::ST_DONE;
      tcw_pkg::ST_DONE:  state_next = tcw_pkg::ST_IDLE;
      default:           state_next = tcw_pkg::ST_IDLE;
    endcase
  end

  // Handshake outputs
  always_comb begin
    busy = (state != tcw_pkg::ST_IDLE);
    done = (state == tcw_pkg::ST_DONE);
  end

  // Datapath: cursor arithmetic and memory requests
  always_comb begin
    cnt_next          = cnt;
    clear_item_next   = clear_item;
    start_cell_next   = start_cell;
    cursor_cell_next  = cursor_cell;
    column_next       = column;
    row_next          = row;
    shown_cursor_next = shown_cursor;
    char_q_next       = char_q;
    last_q_next       = last_q;
    write_q_next      = write_q;
    tail_q_next       = tail_q;
    read_q_next       = read_q;

    ram_req.we    = 1'b0;
    ram_req.waddr = cursor_cell;
    ram_req.wdata = tcw_pkg::BLANK_CELL;
    ram_req.raddr = cell_index;

    case (state)
      tcw_pkg::ST_CLEAR: begin
        // Sweep every cell back to blank
        ram_req.we    = 1'b1;
        ram_req.waddr = cnt[AW-1:0];
        cnt_next      = cnt + NW'(1);
      end

      tcw_pkg::ST_IDLE: begin
        if (start) begin
          char_q_next  = char_code;
          last_q_next  = last_in_write;
          write_q_next = (mode == tcw_pkg::MODE_WRITE);
          read_q_next  = '0;
          cnt_next     = '0;
          case (mode)
            tcw_pkg::MODE_WRITE: begin
              if (is_ign) begin
                // nothing to do
              end else if (is_bs) begin
                if (column != '0) begin
                  column_next      = column - CW'(1);
                  cursor_cell_next = cursor_cell - AW'(1);
                  ram_req.we       = 1'b1;
                  ram_req.waddr    = cursor_cell - AW'(1);
                end
              end else if (is_del) begin
                ram_req.we = 1'b1;
              end else if (is_cr) begin
                cursor_cell_next = cursor_cell - AW'(column);
                column_next      = '0;
              end else if (need_lf) begin
                if (is_lf) begin
                  tail_q_next = tcw_pkg::TAIL_CR;
                end else if (is_ff) begin
                  tail_q_next = tcw_pkg::TAIL_NONE;
                end else begin
                  tail_q_next = tcw_pkg::TAIL_PUT;
                end
                // Take the pending wrap back to column 0 of this row first
                if (is_put) begin
                  column_next      = column - CW'(tcw_pkg::COLUMNS);
                  cursor_cell_next = cursor_cell - AW'(tcw_pkg::COLUMNS);
                end
                if (!at_last_row) begin
                  row_next         = row + RW'(1);
                  cursor_cell_next = (is_put ? cursor_cell - AW'(tcw_pkg::COLUMNS)
                                             : cursor_cell) + AW'(tcw_pkg::COLUMNS);
                end
              end else begin
                ram_req.we       = 1'b1;
                ram_req.wdata    = {text_attribute, char_code};
                cursor_cell_next = cursor_cell + AW'(1);
                column_next      = column + CW'(1);
              end
            end
            tcw_pkg::MODE_CLEAR: begin
              clear_item_next   = 1'b1;
              start_cell_next   = '0;
              cursor_cell_next  = '0;
              column_next       = '0;
              row_next          = '0;
              shown_cursor_next = '0;
            end
            default: begin
              // read address already on the port; unused mode changes nothing
            end
          endcase
        end
      end

      tcw_pkg::ST_READ: begin
        read_q_next = ram_rdata;
      end

      tcw_pkg::ST_BLANK: begin
        // Blank the row just below the screen, then advance start and cursor
        ram_req.we    = 1'b1;
        ram_req.waddr = start_cell + AW'(tcw_pkg::SCREEN_CELLS) + cnt[AW-1:0];
        cnt_next      = cnt + NW'(1);
        if (blank_end) begin
          start_cell_next  = start_cell + AW'(tcw_pkg::COLUMNS);
          cursor_cell_next = cursor_cell + AW'(tcw_pkg::COLUMNS);
        end
      end

      tcw_pkg::ST_COPY: begin
        // Read each source cell the cycle before it is written to its destination
        ram_req.raddr = start_cell + cnt[AW-1:0];
        ram_req.we    = (cnt != '0);
        ram_req.waddr = cnt[AW-1:0] - AW'(1);
        ram_req.wdata = ram_rdata;
        cnt_next      = cnt + NW'(1);
        if (copy_end) begin
          cursor_cell_next = cursor_cell - start_cell;
          start_cell_next  = '0;
        end
      end

      tcw_pkg::ST_TAIL: begin
        case (tail_q)
          tcw_pkg::TAIL_CR: begin
            cursor_cell_next = cursor_cell - AW'(column);
            column_next      = '0;
          end
          tcw_pkg::TAIL_PUT: begin
            ram_req.we       = 1'b1;
            ram_req.wdata    = {text_attribute, char_q};
            cursor_cell_next = cursor_cell + AW'(1);
            column_next      = column + CW'(1);
          end
          default: begin
          end
        endcase
      end

      tcw_pkg::ST_DONE: begin
        clear_item_next = 1'b0;
      end

      default: begin
      end
    endcase

    // Latch the hardware cursor as the last character of a write completes
    if (state_next == tcw_pkg::ST_DONE && state != tcw_pkg::ST_DONE && cur_write && cur_last) begin
      shown_cursor_next = cursor_cell_next;
    end
  end

  // Register write on the access beat
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= tcw_pkg::ST_CLEAR;
      cnt            <= '0;
      clear_item     <= 1'b0;
      start_cell     <= '0;
      cursor_cell    <= '0;
      column         <= '0;
      row            <= '0;
      shown_cursor   <= '0;
      text_attribute <= tcw_pkg::ATTR_DEFAULT;
    end else begin
      state        <= state_next;
      cnt          <= cnt_next;
      clear_item   <= clear_item_next;
      start_cell   <= start_cell_next;
      cursor_cell  <= cursor_cell_next;
      column       <= column_next;
      row          <= row_next;
      shown_cursor <= shown_cursor_next;
      if (cfg_write && paddr[2] == tcw_pkg::REG_TEXT_ATTRIBUTE) begin
        text_attribute <= pwdata[7:0];
      end
    end
  end

  // Payload holds: no reset
  always_ff @(posedge clk) begin
    char_q  <= char_q_next;
    last_q  <= last_q_next;
    write_q <= write_q_next;
    tail_q  <= tail_q_next;
    read_q  <= read_q_next;
  end

  tcw_cell_ram u_ram (
    .clk   (clk),
    .req   (ram_req),
    .rdata (ram_rdata)
  );

  // Result fields show the live state; done marks the beat
  assign read_cell     = read_q;
  assign display_start = start_cell;
  assign hw_cursor     = shown_cursor;
  assign cursor_column = column;
  assign cursor_row    = row;

  // Register read-back
  assign pready = 1'b1;
  assign prdata = (paddr[2] == tcw_pkg::REG_TEXT_ATTRIBUTE) ? {24'b0, text_attribute} : 32'b0;

endmodule

`default_nettype wire

// ===== src/tcw_checker.sv =====
// Port-level checks on the text console writer, bound to the top level.
// Depends on tcw_pkg and text_console_writer_top.
`timescale 1ns / 1ps
`default_nettype none

module tcw_checker (
  input wire logic                        clk,
  input wire logic                        rst,
  input wire logic                        start,
  input wire logic                        busy,
  input wire logic                        done,
  input wire logic [tcw_pkg::ADDR_W-1:0]  display_start,
  input wire logic [tcw_pkg::ADDR_W-1:0]  hw_cursor,
  input wire logic [tcw_pkg::COL_W-1:0]   cursor_column,
  input wire logic [tcw_pkg::ROW_W-1:0]   cursor_row
);

  // An accepted item keeps the block busy until its beat is out
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("item accepted but block not busy");

  // One beat per item, and never while a new item could be taken
  a_done_single: assert property (@(posedge clk) disable iff (rst)
    done |-> busy ##1 !done)
    else $error("result beat repeated or shown while idle");

  // Cursor row stays on the screen; column may reach COLUMNS with a wrap pending
  a_cursor_range: assert property (@(posedge clk) disable iff (rst)
    done |-> (cursor_column <= tcw_pkg::COL_W'(tcw_pkg::COLUMNS) &&
              cursor_row < tcw_pkg::ROW_W'(tcw_pkg::ROWS)))
    else $error("cursor outside the screen");

  // Start and shown cursor hold while no item is in flight
  a_idle_stable: assert property (@(posedge clk) disable iff (rst)
    (!busy && !$past(busy)) |-> ($stable(display_start) && $stable(hw_cursor)))
    else $error("console state moved while idle");

endmodule

bind text_console_writer_top tcw_checker u_tcw_checker (
  .clk           (clk),
  .rst           (rst),
  .start         (start),
  .busy          (busy),
  .done          (done),
  .display_start (display_start),
  .hw_cursor     (hw_cursor),
  .cursor_column (cursor_column),
  .cursor_row    (cursor_row)
);

`default_nettype wire
